// ===== sv/cpg_pkg.sv =====
// Shared constants, types and command/status words for the circle point generator.
`default_nettype none

package cpg_pkg;

    localparam int RADIUS_MAX = 31;
    localparam int COORD_BITS = 11;
    localparam int STEP_CAP   = 64;

    localparam int CW  = 11;
    localparam int RW  = 5;
    localparam int OW  = 13;
    localparam int XW  = 7;
    localparam int DW  = 10;
    localparam int EW  = 12;
    localparam int NW  = 6;

    localparam logic [CW-1:0] CMASK      = CW'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [RW-1:0] RADIUS_SAT = RW'(RADIUS_MAX);
    localparam logic [NW-1:0] COUNT_LAST = NW'(STEP_CAP - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/cpg_ctrl.sv =====
// Controller state machine: accepts a request and paces the steps against the output stall.
`default_nettype none

module cpg_ctrl import cpg_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  wire logic  i_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.step  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_stat.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/cpg_datapath.sv =====
// Datapath: offset and error registers, step decision and output word register.
`default_nettype none

module cpg_datapath import cpg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire t_cmd                 i_cmd,
    input  wire logic [CW-1:0]        i_center_x,
    input  wire logic [CW-1:0]        i_center_y,
    input  wire logic [RW-1:0]        i_radius,
    output t_stat                     o_stat,
    output logic signed [OW-1:0]      o_east_x,
    output logic signed [OW-1:0]      o_west_x,
    output logic signed [OW-1:0]      o_south_y,
    output logic signed [OW-1:0]      o_north_y,
    output logic                      o_last_step
);

    logic        [CW-1:0] r_cx, r_cy;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [DW-1:0] r_delta, n_delta;
    logic        [NW-1:0] r_count;
    logic signed [OW-1:0] r_east_x, r_west_x, r_south_y, r_north_y;
    logic                 r_last;

    logic        [RW-1:0] rad;
    logic signed [EW-1:0] d_ext, y_ext, x_ext, err, d_new;
    logic signed [OW-1:0] cx_ext, cy_ext, xo_ext, yo_ext;

    always_comb begin
        rad    = (i_radius > RADIUS_SAT) ? RADIUS_SAT : i_radius;
        d_ext  = EW'(r_delta);
        y_ext  = EW'(r_y);
        x_ext  = EW'(r_x);
        err    = ((d_ext + y_ext) <<< 1) - EW'(1);
        n_x    = r_x;
        n_y    = r_y;
        if (r_delta < 0 && err <= 0) begin
            n_x   = r_x + XW'(1);
            d_new = d_ext + (x_ext <<< 1) + EW'(3);
        end else if (r_delta > 0 && err > 0) begin
            n_y   = r_y - XW'(1);
            d_new = d_ext - (y_ext <<< 1) + EW'(1);
        end else begin
            n_x   = r_x + XW'(1);
            n_y   = r_y - XW'(1);
            d_new = d_ext + ((x_ext - y_ext) <<< 1) + EW'(2);
        end
        n_delta     = DW'(d_new);
        o_stat.last = (n_y < 0) || (r_count == COUNT_LAST);
        cx_ext      = OW'(r_cx);
        cy_ext      = OW'(r_cy);
        xo_ext      = OW'(r_x);
        yo_ext      = OW'(r_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_center_x & CMASK;
            r_cy    <= i_center_y & CMASK;
            r_x     <= '0;
            r_y     <= XW'(rad);
            r_delta <= DW'(1) - (DW'(rad) <<< 1);
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_east_x  <= cx_ext + xo_ext;
            r_west_x  <= cx_ext - xo_ext;
            r_south_y <= cy_ext + yo_ext;
            r_north_y <= cy_ext - yo_ext;
            r_last    <= o_stat.last;
            r_x       <= n_x;
            r_y       <= n_y;
            r_delta   <= n_delta;
            r_count   <= r_count + NW'(1);
        end
    end

    assign o_east_x    = r_east_x;
    assign o_west_x    = r_west_x;
    assign o_south_y   = r_south_y;
    assign o_north_y   = r_north_y;
    assign o_last_step = r_last;

endmodule

`default_nettype wire

// ===== sv/circle_point_generator_top.sv =====
// Top level of the circle point generator: controller and datapath.
//
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------------------------
//  request  | i_valid / o_stall  | i_center_x, i_center_y, i_radius
//  points   | o_valid / i_stall  | o_east_x, o_west_x, o_south_y, o_north_y,
//           |                    | o_last_step
//
// A request is loaded, then one point word follows per cycle while the output is not
// stalled, up to 64 words per circle, paced by the single step unit.
// A word held in the output register under stall holds the walk; the next request
// is taken once the last word of the circle has been loaded into that register.
// Synchronous active-low reset returns the controller to idle with no word pending.
`default_nettype none

module circle_point_generator_top import cpg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [CW-1:0]        i_center_x,
    input  wire logic [CW-1:0]        i_center_y,
    input  wire logic [RW-1:0]        i_radius,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [OW-1:0]      o_east_x,
    output logic signed [OW-1:0]      o_west_x,
    output logic signed [OW-1:0]      o_south_y,
    output logic signed [OW-1:0]      o_north_y,
    output logic                      o_last_step
);

    t_cmd  cmd;
    t_stat stat;

    cpg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cpg_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .o_stat      (stat),
        .o_east_x    (o_east_x),
        .o_west_x    (o_west_x),
        .o_south_y   (o_south_y),
        .o_north_y   (o_north_y),
        .o_last_step (o_last_step)
    );

endmodule

`default_nettype wire
